// File: src/timer_expiry_scheduler_defines.svh
// Assertion macros for the timer expiry scheduler
`ifndef TIMER_EXPIRY_SCHEDULER_DEFINES_SVH
`define TIMER_EXPIRY_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define TES_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define TES_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TES_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define TES_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// File: src/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and codes of the timer expiry scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_ARM    = 3'd1;
    localparam logic [2:0] FUNC_REARM  = 3'd2;
    localparam logic [2:0] FUNC_CANCEL = 3'd3;
    localparam logic [2:0] FUNC_DRAIN  = 3'd4;
    localparam logic [2:0] FUNC_QUERY  = 3'd5;
    localparam logic [2:0] FUNC_ADJ    = 3'd6;

    localparam logic [1:0] EV_FIRE  = 2'd0;
    localparam logic [1:0] EV_QUEUE = 2'd1;
    localparam logic [1:0] EV_DFIRE = 2'd2;
    localparam logic [1:0] EV_DONE  = 2'd3;

    localparam logic [1:0] REG_TICK_NS  = 2'd0;
    localparam logic [1:0] REG_FRAC     = 2'd1;
    localparam logic [1:0] REG_DENOM    = 2'd2;
    localparam logic [1:0] REG_DEF_MASK = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         timer_id;
        logic [31:0]        delay_ticks;
        logic signed [31:0] adj_value;
        logic [31:0]        adj_ticks;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  timer_id_out;
        logic        flag;
        logic [63:0] tick_count;
        logic [63:0] time_ns;
        logic        last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture command
        logic clk_adv;    // advance clock (tick)
        logic frac_fix;   // apply fractional carry step
        logic scan_clr;   // start a scan pass
        logic scan_step;  // compare one entry
        logic take_best;  // retire best candidate, emit event
        logic do_cmd;     // execute single-entry command
        logic emit_done;  // emit command-done result
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic found;
        logic out_busy;
    } sts_t;

endpackage

// File: src/tes_ctrl.sv
// ----------------------------------------------------------------------------
// tes_ctrl
// Sequencer of the timer expiry scheduler: command, scan and emit steps.
// ----------------------------------------------------------------------------
`include "timer_expiry_scheduler_defines.svh"
module tes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        cmd_func,
    input  tes_pkg::sts_t     sts,
    output tes_pkg::ctl_t     ctl
);
    import tes_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_FRAC = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_TAKE = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_func == FUNC_TICK) begin
                    ctl.clk_adv = 1'b1;
                    state_next = ST_FRAC;
                end else if (cmd_func == FUNC_DRAIN) begin
                    ctl.scan_clr = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    ctl.do_cmd = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_FRAC: begin
                ctl.frac_fix = 1'b1;
                ctl.scan_clr = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                ctl.scan_step = 1'b1;
                if (sts.scan_end) begin
                    state_next = ST_TAKE;
                end
            end
            ST_TAKE: begin
                if (!sts.found) begin
                    state_next = ST_DONE;
                end else if (!sts.out_busy) begin
                    ctl.take_best = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    ctl.emit_done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `TES_ASSERT_NXT(a_load_exec, aclk, aresetn, ctl.load, state_reg == ST_EXEC,
        "load not followed by execute")
    `TES_ASSERT_IMP(a_take_free, aclk, aresetn, ctl.take_best || ctl.emit_done,
        !sts.out_busy, "emit into a full output register")
    `TES_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready,
        !ctl.scan_step && !ctl.take_best, "accepting while scanning")

endmodule

// File: src/tes_dpath.sv
// ----------------------------------------------------------------------------
// tes_dpath
// Datapath: clock, timer table, one-entry-per-cycle scan, output register.
// ----------------------------------------------------------------------------
`include "timer_expiry_scheduler_defines.svh"
module tes_dpath #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tes_pkg::in_item_t   s_data,
    input  tes_pkg::ctl_t       ctl,
    output tes_pkg::sts_t       sts,
    output logic [2:0]          cmd_func,
    input  logic [31:0]         tick_ns,
    input  logic [31:0]         residue_step,
    input  logic [31:0]         residue_limit,
    input  logic [15:0]         deferred_mask,
    output logic                m_valid,
    input  logic                m_ready,
    output tes_pkg::out_item_t  m_data
);
    import tes_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    in_item_t    cmd_reg;
    logic [63:0] ticks_reg, clock_reg;
    logic [31:0] frac_reg, adj_amt_reg, adj_left_reg, stamp_reg;
    logic [31:0] frac_sum_reg;
    logic        flag_reg;
    logic [63:0] exp_reg   [NUM_TIMERS];
    logic        pend_reg  [NUM_TIMERS];
    logic [31:0] dstamp_reg[NUM_TIMERS];

    // scan state
    logic [CW-1:0] scan_idx_reg;
    logic [IW-1:0] best_idx_reg;
    logic [63:0]   best_key_reg;
    logic          found_reg;

    out_item_t out_reg;
    logic      out_valid_reg;

    logic        is_drain;
    logic [IW-1:0] sidx;
    logic        cand;
    logic [63:0] key;
    logic        id_ok;
    logic [IW-1:0] cid;
    logic [64:0] exp_sum;
    logic [63:0] exp_new;
    logic [31:0] best_idx_w;
    logic        best_def;

    assign cmd_func = cmd_reg.func;
    assign is_drain = (cmd_reg.func == FUNC_DRAIN);
    assign sidx     = scan_idx_reg[IW-1:0];
    assign id_ok    = ({28'd0, cmd_reg.timer_id} < 32'(NUM_TIMERS));
    assign cid      = IW'(cmd_reg.timer_id);
    assign exp_sum  = {1'b0, ticks_reg} + {33'd0, (cmd_reg.delay_ticks == 32'd0)
                      ? 32'd1 : cmd_reg.delay_ticks};
    assign exp_new  = exp_sum[64] ? '1 : exp_sum[63:0];
    assign best_idx_w = 32'(best_idx_reg);
    assign best_def = (best_idx_w < 32'd16) && deferred_mask[best_idx_w[3:0]];

    // candidate key of the scanned entry: expiry (earliest wins) or age (max age wins)
    always_comb begin
        if (is_drain) begin
            cand = pend_reg[sidx];
            key  = {32'd0, stamp_reg - dstamp_reg[sidx]};
        end else begin
            cand = (exp_reg[sidx] != 64'd0) && (exp_reg[sidx] <= ticks_reg);
            key  = exp_reg[sidx];
        end
    end

    assign sts.scan_end = (scan_idx_reg == CW'(NUM_TIMERS - 1));
    assign sts.found    = found_reg;
    assign sts.out_busy = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // clock, command and scan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg    <= '0;
            clock_reg    <= '0;
            frac_reg     <= '0;
            adj_amt_reg  <= '0;
            adj_left_reg <= '0;
            stamp_reg    <= '0;
            flag_reg     <= 1'b0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                exp_reg[i]  <= '0;
                pend_reg[i] <= 1'b0;
            end
        end else begin
            if (ctl.load) begin
                cmd_reg  <= s_data;
                flag_reg <= 1'b0;
            end
            // advance tick and clock, stage the residue sum
            if (ctl.clk_adv) begin
                ticks_reg <= ticks_reg + 64'd1;
                if (adj_left_reg != 32'd0) begin
                    clock_reg    <= clock_reg + {32'd0, tick_ns + adj_amt_reg};
                    adj_left_reg <= adj_left_reg - 32'd1;
                end else begin
                    clock_reg <= clock_reg + {32'd0, tick_ns};
                end
                frac_sum_reg <= frac_reg + residue_step;
            end
            if (ctl.frac_fix) begin
                if (frac_sum_reg >= residue_limit) begin
                    frac_reg  <= frac_sum_reg - residue_limit;
                    clock_reg <= clock_reg + 64'd1;
                end else begin
                    frac_reg <= frac_sum_reg;
                end
            end
            if (ctl.scan_clr) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            // compare one entry, keep best
            if (ctl.scan_step) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
                if (cand && (!found_reg || (is_drain ? (key > best_key_reg)
                                                     : (key < best_key_reg)))) begin
                    found_reg    <= 1'b1;
                    best_idx_reg <= sidx;
                    best_key_reg <= key;
                end
            end
            // retire best entry
            if (ctl.take_best) begin
                if (is_drain) begin
                    pend_reg[best_idx_reg] <= 1'b0;
                end else begin
                    exp_reg[best_idx_reg] <= '0;
                    if (best_def) begin
                        pend_reg[best_idx_reg]   <= 1'b1;
                        dstamp_reg[best_idx_reg] <= stamp_reg;
                        stamp_reg                <= stamp_reg + 32'd1;
                        flag_reg                 <= 1'b1;
                    end
                end
            end
            // single-entry commands
            if (ctl.do_cmd) begin
                case (cmd_reg.func)
                    FUNC_ARM, FUNC_REARM: begin
                        if (id_ok && (cmd_reg.func == FUNC_ARM
                                      || exp_reg[cid] != 64'd0)) begin
                            exp_reg[cid] <= exp_new;
                            flag_reg     <= (cmd_reg.func == FUNC_REARM);
                        end
                    end
                    FUNC_CANCEL: begin
                        if (id_ok) begin
                            if (exp_reg[cid] != 64'd0) begin
                                exp_reg[cid] <= '0;
                                flag_reg     <= 1'b1;
                            end else if (pend_reg[cid]) begin
                                pend_reg[cid] <= 1'b0;
                                flag_reg      <= 1'b1;
                            end
                        end
                    end
                    FUNC_QUERY: begin
                        flag_reg <= id_ok && (exp_reg[cid] != 64'd0 || pend_reg[cid]);
                    end
                    FUNC_ADJ: begin
                        adj_amt_reg  <= cmd_reg.adj_value;
                        adj_left_reg <= cmd_reg.adj_ticks;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.take_best) begin
                out_valid_reg <= 1'b1;
                out_reg.event_res    <= is_drain ? EV_DFIRE : (best_def ? EV_QUEUE : EV_FIRE);
                out_reg.timer_id_out <= 4'(best_idx_reg);
                out_reg.flag         <= 1'b0;
                out_reg.tick_count   <= ticks_reg;
                out_reg.time_ns      <= clock_reg;
                out_reg.last         <= 1'b0;
            end else if (ctl.emit_done) begin
                out_valid_reg <= 1'b1;
                out_reg.event_res  <= EV_DONE;
                out_reg.timer_id_out <= (cmd_reg.func == FUNC_ARM || cmd_reg.func == FUNC_REARM
                    || cmd_reg.func == FUNC_CANCEL || cmd_reg.func == FUNC_QUERY)
                    ? cmd_reg.timer_id : 4'd0;
                out_reg.flag       <= (cmd_reg.func == FUNC_TICK || cmd_reg.func == FUNC_REARM
                    || cmd_reg.func == FUNC_CANCEL || cmd_reg.func == FUNC_QUERY)
                    ? flag_reg : 1'b0;
                out_reg.tick_count <= ticks_reg;
                out_reg.time_ns    <= clock_reg;
                out_reg.last       <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `TES_ASSERT_IMP(a_take_found, aclk, aresetn, ctl.take_best, found_reg,
        "retire without candidate")
    `TES_ASSERT_NXT(a_tick_adv, aclk, aresetn, ctl.clk_adv,
        ticks_reg == $past(ticks_reg) + 64'd1, "tick count not advanced")
    `TES_ASSERT_IMP(a_scan_range, aclk, aresetn, ctl.scan_step,
        scan_idx_reg < CW'(NUM_TIMERS), "scan index out of range")

endmodule

// File: src/timer_expiry_scheduler.sv
// Timer expiry scheduler: a command runs through the execute and done steps; a
// tick first advances the clock and applies the fractional carry, and a tick or
// drain then repeats a table scan and a retire step for each event emitted, with
// a single comparator that scans one table entry per cycle; retire and done wait
// while the output register is full. The block accepts one command at a time and
// holds it until its done result (last = 1) is loaded into the output register.
// ----------------------------------------------------------------------------
// timer_expiry_scheduler
// Top level: APB register file, sequencer and datapath.
// ----------------------------------------------------------------------------
module timer_expiry_scheduler #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  tes_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tes_pkg::out_item_t  m_data
);
    import tes_pkg::*;

    logic [31:0] tick_ns_reg, frac_reg, denom_reg;
    logic [15:0] mask_reg;
    ctl_t        ctl;
    sts_t        sts;
    logic [2:0]  cmd_func;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_ns_reg <= 32'd1000000;
            frac_reg    <= '0;
            denom_reg   <= 32'd1;
            mask_reg    <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_TICK_NS:  tick_ns_reg <= pwdata;
                REG_FRAC:     frac_reg    <= pwdata;
                REG_DENOM:    denom_reg   <= pwdata;
                REG_DEF_MASK: mask_reg    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[3:2])
            REG_TICK_NS:  prdata = tick_ns_reg;
            REG_FRAC:     prdata = frac_reg;
            REG_DENOM:    prdata = denom_reg;
            REG_DEF_MASK: prdata = {16'd0, mask_reg};
            default:      prdata = '0;
        endcase
    end

    tes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .cmd_func (cmd_func),
        .sts      (sts),
        .ctl      (ctl)
    );

    tes_dpath #(.NUM_TIMERS(NUM_TIMERS)) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data        (s_data),
        .ctl           (ctl),
        .sts           (sts),
        .cmd_func      (cmd_func),
        .tick_ns       (tick_ns_reg),
        .residue_step  (frac_reg),
        .residue_limit (denom_reg),
        .deferred_mask (mask_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
